>>> src/icr_pkg.sv
// Shared constants, request codes and control types of the implicant chart reducer.
`default_nettype none

package icr_pkg;

	localparam int NUM_VARS       = 8;
	localparam int MAX_IMPLICANTS = 16;
	localparam int MAX_MINTERMS   = 64;
	localparam int RESULT_LIMIT   = 16;

	localparam int TERM_W     = 8;
	localparam int REQ_W      = 2;
	localparam int KEPT_IDX_W = 4;

	localparam int IMP_IDX_W = (MAX_IMPLICANTS > 1) ? $clog2(MAX_IMPLICANTS) : 1;
	localparam int IMP_CNT_W = $clog2(MAX_IMPLICANTS + 1);
	localparam int MT_IDX_W  = (MAX_MINTERMS > 1) ? $clog2(MAX_MINTERMS) : 1;
	localparam int MT_CNT_W  = $clog2(MAX_MINTERMS + 1);
	localparam int RES_CNT_W = $clog2(RESULT_LIMIT + 1);

	// care bits that take part in matching
	localparam logic [TERM_W-1:0] VAR_MASK =
		(NUM_VARS >= TERM_W) ? {TERM_W{1'b1}} : TERM_W'((1 << NUM_VARS) - 1);

	typedef enum logic [REQ_W-1:0] {
		REQ_LOAD_IMP = 2'd0,
		REQ_LOAD_MT  = 2'd1,
		REQ_RUN      = 2'd2
	} req_code_t;

	typedef struct packed {
		logic                 imp_we;
		logic [IMP_IDX_W-1:0] imp_waddr;
		logic                 mt_we;
		logic [MT_IDX_W-1:0]  mt_waddr;
		logic [TERM_W-1:0]    wr_value;
		logic [TERM_W-1:0]    wr_mask;
		logic                 mt_re;
		logic [MT_IDX_W-1:0]  mt_raddr;
		logic [IMP_IDX_W-1:0] imp_raddr;
	} store_ctl_t;

	typedef struct packed {
		logic                  valid;
		logic [KEPT_IDX_W-1:0] index;
		logic [TERM_W-1:0]     value;
		logic [TERM_W-1:0]     mask;
		logic                  none;
		logic                  last;
	} emit_t;

endpackage

`default_nettype wire

>>> src/icr_req_if.sv
// Request channel: valid/ready handshake with one load or run request.
`default_nettype none

interface icr_req_if import icr_pkg::*; ();
	logic              valid;
	logic              ready;
	logic [REQ_W-1:0]  req_type;
	logic [TERM_W-1:0] term_value;
	logic [TERM_W-1:0] term_mask;

	modport source (output valid, req_type, term_value, term_mask, input ready);
	modport sink   (input valid, req_type, term_value, term_mask, output ready);
endinterface

`default_nettype wire

>>> src/icr_rsp_if.sv
// Result channel: valid/ready handshake with one kept implicant per transfer.
`default_nettype none

interface icr_rsp_if import icr_pkg::*; ();
	logic                  valid;
	logic                  ready;
	logic [KEPT_IDX_W-1:0] kept_index;
	logic [TERM_W-1:0]     kept_value;
	logic [TERM_W-1:0]     kept_mask;
	logic                  none_kept;
	logic                  last_result;

	modport source (output valid, kept_index, kept_value, kept_mask, none_kept, last_result,
		input ready);
	modport sink   (input valid, kept_index, kept_value, kept_mask, none_kept, last_result,
		output ready);
endinterface

`default_nettype wire

>>> src/icr_store.sv
// Implicant registers, minterm memory and the shared cover comparator.
`default_nettype none

module icr_store import icr_pkg::*; (
	input  wire logic              clk,
	input  wire store_ctl_t        ctl,
	output logic                   cover_hit,
	output logic [TERM_W-1:0]      imp_value,
	output logic [TERM_W-1:0]      imp_mask
);

	logic [TERM_W-1:0] imp_val_q  [MAX_IMPLICANTS];
	logic [TERM_W-1:0] imp_mask_q [MAX_IMPLICANTS];
	logic [TERM_W-1:0] mt_mem_q   [MAX_MINTERMS];
	logic [TERM_W-1:0] mt_rd_q;

	always_ff @(posedge clk) begin
		if (ctl.imp_we) begin
			imp_val_q[ctl.imp_waddr]  <= ctl.wr_value;
			imp_mask_q[ctl.imp_waddr] <= ctl.wr_mask;
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.mt_we) begin
			mt_mem_q[ctl.mt_waddr] <= ctl.wr_value;
		end
		if (ctl.mt_re) begin
			mt_rd_q <= mt_mem_q[ctl.mt_raddr];
		end
	end

	assign imp_value = imp_val_q[ctl.imp_raddr];
	assign imp_mask  = imp_mask_q[ctl.imp_raddr];

	// match on every care bit against the registered minterm fetched last
	assign cover_hit = ~|((imp_value ^ mt_rd_q) & imp_mask & VAR_MASK);

endmodule

`default_nettype wire

>>> src/icr_seq.sv
// Sequencer: loads, chart reduction walk, alive bits and result emission.
`default_nettype none

module icr_seq import icr_pkg::*; (
	input  wire logic         clk,
	input  wire logic         arst_n,
	icr_req_if.sink           req,
	input  wire logic         out_free,
	input  wire logic         cover_hit,
	input  wire logic [TERM_W-1:0] imp_value,
	input  wire logic [TERM_W-1:0] imp_mask,
	output store_ctl_t        ctl,
	output emit_t             emit
);

	typedef enum logic [6:0] {
		ST_IDLE     = 7'b0000001,
		ST_NEXT_I   = 7'b0000010,
		ST_MT_FETCH = 7'b0000100,
		ST_CHK_I    = 7'b0001000,
		ST_SCAN_K   = 7'b0010000,
		ST_EMIT     = 7'b0100000,
		ST_NONE     = 7'b1000000
	} state_t;

	state_t                  state_q;
	logic [MAX_IMPLICANTS-1:0] alive_q;
	logic [IMP_CNT_W-1:0]    imp_cnt_q;
	logic [MT_CNT_W-1:0]     mt_cnt_q;
	logic [IMP_CNT_W-1:0]    i_q;
	logic [IMP_CNT_W-1:0]    k_q;
	logic [MT_CNT_W-1:0]     j_q;
	logic [RES_CNT_W-1:0]    n_q;
	logic                    keep_q;

	logic                    accept;
	logic                    imp_room;
	logic                    mt_room;
	logic [IMP_IDX_W-1:0]    i_idx;
	logic [IMP_IDX_W-1:0]    k_idx;
	logic [MAX_IMPLICANTS-1:0] above;
	logic                    later_none;

	assign req.ready = (state_q == ST_IDLE);
	assign accept    = req.valid && (state_q == ST_IDLE);
	assign imp_room  = (imp_cnt_q < IMP_CNT_W'(MAX_IMPLICANTS));
	assign mt_room   = (mt_cnt_q < MT_CNT_W'(MAX_MINTERMS));
	assign i_idx     = i_q[IMP_IDX_W-1:0];
	assign k_idx     = k_q[IMP_IDX_W-1:0];

	always_comb begin
		for (int b = 0; b < MAX_IMPLICANTS; b++) begin
			above[b] = (IMP_CNT_W'(b) > i_q);
		end
		later_none = ~|(alive_q & above);
	end

	always_comb begin
		ctl           = '0;
		ctl.wr_value  = req.term_value;
		ctl.wr_mask   = req.term_mask;
		ctl.imp_waddr = imp_cnt_q[IMP_IDX_W-1:0];
		ctl.mt_waddr  = mt_cnt_q[MT_IDX_W-1:0];
		ctl.mt_raddr  = j_q[MT_IDX_W-1:0];
		ctl.imp_raddr = (state_q == ST_SCAN_K) ? k_idx : i_idx;
		ctl.imp_we    = accept && (req.req_type == REQ_LOAD_IMP) && imp_room;
		ctl.mt_we     = accept && (req.req_type == REQ_LOAD_MT) && mt_room;
		ctl.mt_re     = (state_q == ST_MT_FETCH) && !keep_q && (j_q != mt_cnt_q);

		emit = '0;
		if (state_q == ST_EMIT && i_q != imp_cnt_q && alive_q[i_idx] && out_free) begin
			emit.valid = 1'b1;
			emit.index = KEPT_IDX_W'(i_idx);
			emit.value = imp_value;
			emit.mask  = imp_mask;
			emit.last  = later_none || (n_q == RES_CNT_W'(RESULT_LIMIT - 1));
		end else if (state_q == ST_NONE && out_free) begin
			emit.valid = 1'b1;
			emit.none  = 1'b1;
			emit.last  = 1'b1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= ST_IDLE;
			alive_q   <= '0;
			imp_cnt_q <= '0;
			mt_cnt_q  <= '0;
			i_q       <= '0;
			k_q       <= '0;
			j_q       <= '0;
			n_q       <= '0;
			keep_q    <= 1'b0;
		end else begin
			unique case (state_q)
				ST_IDLE: begin
					if (ctl.imp_we) begin
						alive_q[ctl.imp_waddr] <= 1'b1;
						imp_cnt_q              <= imp_cnt_q + 1'b1;
					end
					if (ctl.mt_we) begin
						mt_cnt_q <= mt_cnt_q + 1'b1;
					end
					if (accept && req.req_type == REQ_RUN) begin
						i_q     <= '0;
						n_q     <= '0;
						state_q <= ST_NEXT_I;
					end
				end
				ST_NEXT_I: begin
					if (i_q == imp_cnt_q) begin
						i_q     <= '0;
						state_q <= (alive_q == '0) ? ST_NONE : ST_EMIT;
					end else if (!alive_q[i_idx]) begin
						i_q <= i_q + 1'b1;
					end else begin
						keep_q  <= 1'b0;
						j_q     <= '0;
						state_q <= ST_MT_FETCH;
					end
				end
				ST_MT_FETCH: begin
					if (keep_q || j_q == mt_cnt_q) begin
						// drop the row when no minterm needed it
						if (!keep_q) begin
							alive_q[i_idx] <= 1'b0;
						end
						i_q     <= i_q + 1'b1;
						state_q <= ST_NEXT_I;
					end else begin
						state_q <= ST_CHK_I;
					end
				end
				ST_CHK_I: begin
					if (!cover_hit) begin
						j_q     <= j_q + 1'b1;
						state_q <= ST_MT_FETCH;
					end else begin
						k_q     <= '0;
						state_q <= ST_SCAN_K;
					end
				end
				ST_SCAN_K: begin
					if (k_q == imp_cnt_q) begin
						keep_q  <= 1'b1;
						state_q <= ST_MT_FETCH;
					end else if (k_q != i_q && alive_q[k_idx] && cover_hit) begin
						j_q     <= j_q + 1'b1;
						state_q <= ST_MT_FETCH;
					end else begin
						k_q <= k_q + 1'b1;
					end
				end
				ST_EMIT: begin
					if (i_q == imp_cnt_q || (emit.valid && emit.last)) begin
						alive_q   <= '0;
						imp_cnt_q <= '0;
						mt_cnt_q  <= '0;
						state_q   <= ST_IDLE;
					end else if (!alive_q[i_idx]) begin
						i_q <= i_q + 1'b1;
					end else if (emit.valid) begin
						n_q <= n_q + 1'b1;
						i_q <= i_q + 1'b1;
					end
				end
				ST_NONE: begin
					if (emit.valid) begin
						alive_q   <= '0;
						imp_cnt_q <= '0;
						mt_cnt_q  <= '0;
						state_q   <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

endmodule

`default_nettype wire

>>> src/implicant_chart_reducer.sv
// Top level of the implicant chart reducer: sequencer, store and result register.
//
// Usage: requests arrive on req (valid/ready). A load-implicant request stores
// a value and care mask, a load-minterm request stores a full term; a load
// gives no result. Loads past 16 implicants or 64 minterms are dropped. A run
// request reduces the chart: every implicant is checked in load order against
// the minterms it covers, through one cover comparator and one minterm read
// port, and a run also waits out any stall on rsp. ready is low for the whole
// run. Kept implicants then leave on rsp one per transfer, in load order, the
// final one flagged last_result; if none is kept a single none_kept result is
// sent. After a run the chart is empty again.
// rsp has a one-entry output register: the block holds its next result while
// the receiver stalls, and accepts the next request once the run has placed its
// final result there. Reset clears all counts and alive bits; stored terms keep
// stale values that are never read.
`default_nettype none

module implicant_chart_reducer import icr_pkg::*; (
	input  wire logic clk,
	input  wire logic arst_n,
	icr_req_if.sink   req,
	icr_rsp_if.source rsp
);

	store_ctl_t        ctl;
	emit_t             emit;
	logic              cover_hit;
	logic [TERM_W-1:0] imp_value;
	logic [TERM_W-1:0] imp_mask;
	logic              out_free;

	logic                  out_valid_q;
	logic [KEPT_IDX_W-1:0] out_index_q;
	logic [TERM_W-1:0]     out_value_q;
	logic [TERM_W-1:0]     out_mask_q;
	logic                  out_none_q;
	logic                  out_last_q;

	icr_seq u_seq (
		.clk       (clk),
		.arst_n    (arst_n),
		.req       (req),
		.out_free  (out_free),
		.cover_hit (cover_hit),
		.imp_value (imp_value),
		.imp_mask  (imp_mask),
		.ctl       (ctl),
		.emit      (emit)
	);

	icr_store u_store (
		.clk       (clk),
		.ctl       (ctl),
		.cover_hit (cover_hit),
		.imp_value (imp_value),
		.imp_mask  (imp_mask)
	);

	assign out_free = !out_valid_q || rsp.ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (emit.valid) begin
			out_valid_q <= 1'b1;
		end else if (rsp.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (emit.valid) begin
			out_index_q <= emit.index;
			out_value_q <= emit.value;
			out_mask_q  <= emit.mask;
			out_none_q  <= emit.none;
			out_last_q  <= emit.last;
		end
	end

	assign rsp.valid       = out_valid_q;
	assign rsp.kept_index  = out_index_q;
	assign rsp.kept_value  = out_value_q;
	assign rsp.kept_mask   = out_mask_q;
	assign rsp.none_kept   = out_none_q;
	assign rsp.last_result = out_last_q;

`ifndef NO_ASSERTIONS
	// a new result never overwrites one the receiver has not taken
	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		emit.valid |-> (!out_valid_q || rsp.ready))
		else $error("result register overwritten while stalled");

	// no result is produced while new requests are being taken
	a_idle_quiet: assert property (@(posedge clk) disable iff (!arst_n)
		req.ready |-> !emit.valid)
		else $error("result produced while idle");

	// an empty-run result carries zero fields and closes the run
	a_none_form: assert property (@(posedge clk) disable iff (!arst_n)
		(rsp.valid && rsp.none_kept) |->
			(rsp.last_result && rsp.kept_value == '0 && rsp.kept_mask == '0
			&& rsp.kept_index == '0))
		else $error("malformed none_kept result");

	// the final result of a run frees the request side in the next cycle
	a_last_frees: assert property (@(posedge clk) disable iff (!arst_n)
		(emit.valid && emit.last) |=> req.ready)
		else $error("request side not freed after final result");
`endif

endmodule

`default_nettype wire

>>> tb/sv/tb_implicant_chart_reducer.sv
// Testbench for the implicant chart reducer: directed table, random charts, chart predictor.
`default_nettype none

module tb_implicant_chart_reducer;
	import icr_pkg::*;

	// request code the block leaves free
	localparam logic [REQ_W-1:0] REQ_UNUSED = 2'd3;

	typedef struct packed {
		logic [KEPT_IDX_W-1:0] idx;
		logic [TERM_W-1:0]     val;
		logic [TERM_W-1:0]     msk;
		logic                  none_flag;
		logic                  last_flag;
	} kept_t;

	typedef struct packed {
		logic [REQ_W-1:0]  code;
		logic [TERM_W-1:0] val;
		logic [TERM_W-1:0] msk;
		logic              typed;
		kept_t             given;
	} stim_row_t;

	localparam kept_t NO_KEPT = '0;
	localparam int N_ROWS = 21;

	localparam stim_row_t STIM_TABLE [N_ROWS] = '{
		'{REQ_RUN,      8'h00, 8'h00, 1'b1, '{4'd0, 8'h00, 8'h00, 1'b1, 1'b1}},
		'{REQ_LOAD_IMP, 8'hFF, 8'hFF, 1'b0, NO_KEPT},
		'{REQ_LOAD_MT,  8'hFF, 8'h00, 1'b0, NO_KEPT},
		'{REQ_RUN,      8'hFF, 8'hFF, 1'b1, '{4'd0, 8'hFF, 8'hFF, 1'b0, 1'b1}},
		'{REQ_LOAD_IMP, 8'h00, 8'h00, 1'b0, NO_KEPT},
		'{REQ_UNUSED,   8'hAA, 8'h55, 1'b0, NO_KEPT},
		'{REQ_LOAD_MT,  8'h00, 8'hFF, 1'b0, NO_KEPT},
		'{REQ_LOAD_MT,  8'hA5, 8'hFF, 1'b0, NO_KEPT},
		'{REQ_LOAD_IMP, 8'hA5, 8'hFF, 1'b0, NO_KEPT},
		'{REQ_RUN,      8'h5A, 8'h00, 1'b0, NO_KEPT},
		'{REQ_LOAD_IMP, 8'h0F, 8'hFF, 1'b0, NO_KEPT},
		'{REQ_LOAD_MT,  8'h00, 8'h00, 1'b0, NO_KEPT},
		'{REQ_LOAD_IMP, 8'h0F, 8'hF0, 1'b0, NO_KEPT},
		'{REQ_RUN,      8'h00, 8'h00, 1'b0, NO_KEPT},
		'{REQ_LOAD_MT,  8'h00, 8'h00, 1'b0, NO_KEPT},
		'{REQ_LOAD_MT,  8'h01, 8'h00, 1'b0, NO_KEPT},
		'{REQ_LOAD_MT,  8'h03, 8'h00, 1'b0, NO_KEPT},
		'{REQ_LOAD_IMP, 8'h00, 8'hFE, 1'b0, NO_KEPT},
		'{REQ_LOAD_IMP, 8'h01, 8'hFD, 1'b0, NO_KEPT},
		'{REQ_LOAD_IMP, 8'hF0, 8'hFC, 1'b0, NO_KEPT},
		'{REQ_RUN,      8'hFF, 8'h00, 1'b0, NO_KEPT}
	};

	logic clk;
	logic arst_n;

	icr_req_if req_if ();
	icr_rsp_if rsp_if ();

	implicant_chart_reducer dut (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (req_if),
		.rsp    (rsp_if)
	);

	// chart copy kept by the testbench
	logic [TERM_W-1:0]         chart_imp_val [MAX_IMPLICANTS];
	logic [TERM_W-1:0]         chart_imp_msk [MAX_IMPLICANTS];
	logic [MAX_IMPLICANTS-1:0] chart_live = '0;
	int                        chart_imp_cnt = 0;
	logic [TERM_W-1:0]         chart_mt [MAX_MINTERMS];
	int                        chart_mt_cnt = 0;

	kept_t expected_kept [$];
	bit    failed = 1'b0;
	int    issued = 0;
	bit    req_idling = 1'b1;
	bit    rsp_idling = 1'b1;

	initial clk = 1'b0;
	always #5 clk = ~clk;

	function automatic bit imp_covers(int i, int j);
		return ((chart_imp_val[i] ^ chart_mt[j]) & chart_imp_msk[i] & VAR_MASK) == '0;
	endfunction

	// Update the chart copy for one accepted request; queue what a run emits.
	task automatic predict_chart(input logic [REQ_W-1:0] code, input logic [TERM_W-1:0] v,
		input logic [TERM_W-1:0] m, input bit queue_results);
		int  survivors [$];
		bit  keep;
		bit  shared;
		kept_t r;
		case (code)
			REQ_LOAD_IMP: begin
				if (chart_imp_cnt < MAX_IMPLICANTS) begin
					chart_imp_val[chart_imp_cnt] = v;
					chart_imp_msk[chart_imp_cnt] = m;
					chart_live[chart_imp_cnt] = 1'b1;
					chart_imp_cnt++;
				end
			end
			REQ_LOAD_MT: begin
				if (chart_mt_cnt < MAX_MINTERMS) begin
					chart_mt[chart_mt_cnt] = v;
					chart_mt_cnt++;
				end
			end
			REQ_RUN: begin
				// later rows see the set already thinned by earlier drops
				for (int i = 0; i < chart_imp_cnt; i++) begin
					if (!chart_live[i])
						continue;
					keep = 1'b0;
					for (int j = 0; j < chart_mt_cnt && !keep; j++) begin
						if (!imp_covers(i, j))
							continue;
						shared = 1'b0;
						for (int k = 0; k < chart_imp_cnt; k++)
							if (k != i && chart_live[k] && imp_covers(k, j))
								shared = 1'b1;
						if (!shared)
							keep = 1'b1;
					end
					if (!keep)
						chart_live[i] = 1'b0;
				end
				for (int i = 0; i < chart_imp_cnt; i++)
					if (chart_live[i] && survivors.size() < RESULT_LIMIT)
						survivors = {survivors, i};
				if (queue_results) begin
					if (survivors.size() == 0) begin
						r = '{'0, '0, '0, 1'b1, 1'b1};
						expected_kept = {expected_kept, r};
					end else begin
						for (int n = 0; n < survivors.size(); n++) begin
							r.idx       = KEPT_IDX_W'(survivors[n]);
							r.val       = chart_imp_val[survivors[n]];
							r.msk       = chart_imp_msk[survivors[n]];
							r.none_flag = 1'b0;
							r.last_flag = (n == survivors.size() - 1);
							expected_kept = {expected_kept, r};
						end
					end
				end
				chart_live    = '0;
				chart_imp_cnt = 0;
				chart_mt_cnt  = 0;
			end
			default: ; // drop unused code
		endcase
	endtask

	task automatic send_request(input logic [REQ_W-1:0] code, input logic [TERM_W-1:0] v,
		input logic [TERM_W-1:0] m, input bit typed, input kept_t given);
		int gap;
		if ($urandom_range(0, 29) == 0)
			req_idling = !req_idling;
		gap = req_idling ? $urandom_range(0, 5) : 0;
		@(negedge clk);
		if (gap > 0) begin
			req_if.valid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		req_if.valid      <= 1'b1;
		req_if.req_type   <= code;
		req_if.term_value <= v;
		req_if.term_mask  <= m;
		do @(posedge clk); while (!req_if.ready);
		predict_chart(code, v, m, !typed);
		if (typed)
			expected_kept = {expected_kept, given};
		issued++;
	endtask

	// Minterms vary over a few adjacent variables so implicants overlap.
	task automatic random_chart(input int n_imp, input int n_mt);
		logic [TERM_W-1:0] mts [80];
		logic [TERM_W-1:0] free;
		logic [TERM_W-1:0] base;
		logic [TERM_W-1:0] v;
		logic [TERM_W-1:0] m;
		int width;
		int left_imp;
		int left_mt;
		width = $urandom_range(2, 5);
		free  = TERM_W'(((1 << width) - 1) << $urandom_range(0, 8 - width));
		base  = TERM_W'($urandom);
		for (int i = 0; i < n_mt; i++)
			mts[i] = (base & ~free) | (TERM_W'($urandom) & free);
		left_imp = n_imp;
		left_mt  = n_mt;
		while (left_imp + left_mt > 0) begin
			if ($urandom_range(0, 11) == 0)
				send_request(REQ_UNUSED, TERM_W'($urandom), TERM_W'($urandom), 1'b0, NO_KEPT);
			if ($urandom_range(1, left_imp + left_mt) <= left_imp) begin
				if (n_mt == 0 || $urandom_range(0, 9) == 0) begin
					v = TERM_W'($urandom);
					m = TERM_W'($urandom);
				end else begin
					m = ~(free & TERM_W'($urandom) & TERM_W'($urandom));
					if ($urandom_range(0, 7) == 0)
						m = m & TERM_W'($urandom);
					v = (mts[$urandom_range(0, n_mt - 1)] & m) | (TERM_W'($urandom) & ~m);
				end
				send_request(REQ_LOAD_IMP, v, m, 1'b0, NO_KEPT);
				left_imp--;
			end else begin
				send_request(REQ_LOAD_MT, mts[n_mt - left_mt], TERM_W'($urandom), 1'b0,
					NO_KEPT);
				left_mt--;
			end
		end
		send_request(REQ_RUN, TERM_W'($urandom), TERM_W'($urandom), 1'b0, NO_KEPT);
	endtask

	initial begin
		arst_n            = 1'b0;
		req_if.valid      = 1'b0;
		req_if.req_type   = REQ_LOAD_IMP;
		req_if.term_value = '0;
		req_if.term_mask  = '0;
		repeat (9) @(negedge clk);
		arst_n <= 1'b1;
		for (int i = 0; i < N_ROWS; i++)
			send_request(STIM_TABLE[i].code, STIM_TABLE[i].val, STIM_TABLE[i].msk,
				STIM_TABLE[i].typed, STIM_TABLE[i].given);
		// fill both stores past their limits once
		random_chart(MAX_IMPLICANTS + 1, MAX_MINTERMS + 2);
		while (issued < 320)
			random_chart(($urandom_range(0, 9) == 0) ? 0 : $urandom_range(1, 6),
				($urandom_range(0, 9) == 0) ? 0 : $urandom_range(1, 12));
		@(negedge clk);
		req_if.valid <= 1'b0;
		while (expected_kept.size() != 0)
			@(posedge clk);
		repeat (40) @(posedge clk);
		if (!failed && expected_kept.size() == 0)
			$display("PASS");
		else
			$display("FAIL");
		$finish;
	end

	initial begin
		int gap;
		rsp_if.ready = 1'b0;
		@(posedge arst_n);
		forever begin
			if ($urandom_range(0, 29) == 0)
				rsp_idling = !rsp_idling;
			gap = rsp_idling ? $urandom_range(0, 5) : 0;
			@(negedge clk);
			if (gap > 0) begin
				rsp_if.ready <= 1'b0;
				repeat (gap) @(negedge clk);
			end
			rsp_if.ready <= 1'b1;
			do @(posedge clk); while (!rsp_if.valid);
		end
	end

	always @(posedge clk) begin
		kept_t want;
		if (arst_n && rsp_if.valid && rsp_if.ready) begin
			if (expected_kept.size() == 0) begin
				$error("result with nothing expected: kept_index %0d", rsp_if.kept_index);
				failed = 1'b1;
			end else begin
				want = expected_kept.pop_front();
				if (rsp_if.kept_index !== want.idx) begin
					$error("kept_index: expected %0d, got %0d", want.idx, rsp_if.kept_index);
					failed = 1'b1;
				end
				if (rsp_if.kept_value !== want.val) begin
					$error("kept_value: expected %h, got %h", want.val, rsp_if.kept_value);
					failed = 1'b1;
				end
				if (rsp_if.kept_mask !== want.msk) begin
					$error("kept_mask: expected %h, got %h", want.msk, rsp_if.kept_mask);
					failed = 1'b1;
				end
				if (rsp_if.none_kept !== want.none_flag) begin
					$error("none_kept: expected %b, got %b", want.none_flag, rsp_if.none_kept);
					failed = 1'b1;
				end
				if (rsp_if.last_result !== want.last_flag) begin
					$error("last_result: expected %b, got %b", want.last_flag,
						rsp_if.last_result);
					failed = 1'b1;
				end
			end
		end
	end

	initial begin
		#10_000_000;
		$display("FAIL");
		$finish;
	end

endmodule

`default_nettype wire
